// ===== design/sleb_pkg.sv =====
// Shared constants, types and helpers of the serial line edit buffer.
package sleb_pkg;

   // Line store geometry
   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int POS_W      = $clog2(LINE_DEPTH + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_END_CHAR        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACKSPACE_CHAR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAR_CHAR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO_ENABLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PRINTABLE_FLOOR = 3'd4;

   // Operation codes on the request side
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // Command kinds, each one expands to a fixed response sequence
   localparam logic [2:0] KIND_READ      = 3'd0;
   localparam logic [2:0] KIND_QUIET     = 3'd1;
   localparam logic [2:0] KIND_SINGLE    = 3'd2;
   localparam logic [2:0] KIND_BACKSPACE = 3'd3;
   localparam logic [2:0] KIND_CRLF      = 3'd4;
   localparam logic [2:0] KIND_CLEAR     = 3'd5;

   // Echo characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   typedef struct packed {
      logic [7:0] end_char;
      logic [7:0] backspace_char;
      logic [7:0] clear_char;
      logic       echo_enable;
      logic [7:0] printable_floor;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] rx_byte;
      logic       line_done;
      logic       has_data;
      logic [7:0] read_data;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // Index of the last response of a command kind
   function automatic logic [2:0] last_step(input logic [2:0] kind);
      logic [2:0] n;
      unique case (kind)
         KIND_BACKSPACE: n = 3'd2;
         KIND_CRLF:      n = 3'd2;
         KIND_CLEAR:     n = 3'd7;
         default:        n = 3'd0;
      endcase
      return n;
   endfunction

   // Echo character of a command kind at a given step
   function automatic logic [7:0] echo_char(input logic [2:0] kind, input logic [2:0] step,
                                            input logic [7:0] rx_byte);
      logic [7:0] c;
      c = rx_byte;
      case (kind)
         KIND_BACKSPACE: if (step == 3'd1) c = CHAR_SPACE;
         KIND_CRLF: begin
            if (step == 3'd1) c = CHAR_CR;
            else if (step == 3'd2) c = CHAR_LF;
         end
         KIND_CLEAR: begin
            if (step == 3'd6) c = CHAR_CR;
            else if (step == 3'd7) c = CHAR_LF;
            else if (step != 3'd0) c = CHAR_DOT;
         end
         default: c = rx_byte;
      endcase
      return c;
   endfunction

endpackage

// ===== design/sleb_front.sv =====
// Front end: accepts requests, edits the line store and classifies each transaction.
module sleb_front import sleb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,
   input  logic             req_tuser,
   input  queue_status_type q_stat,
   output logic             push,
   output cmd_type          push_cmd
);

   logic [7:0]            mem [LINE_DEPTH];
   logic [LINE_DEPTH-1:0] valid_ff;
   logic [POS_W-1:0]      pos_ff, pos_in, pos;
   logic                  entry0_ff, entry0_in;
   logic                  stage_valid_ff, stage_valid_in;
   cmd_type               stage_ff, stage_in;
   logic [7:0]            rdata_ff;
   logic                  rvld_ff, rvld_in;

   logic                  accept, is_read, in_range, done, wr_en;
   logic [7:0]            rx, wr_data;
   logic [5:0]            rd_idx;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [2:0]            kind;

   assign rx      = req_tdata[7:0];
   assign rd_idx  = req_tdata[13:8];
   assign is_read = (req_tuser == OP_READ);
   assign rd_addr = ADDR_W'(rd_idx);
   assign in_range = (int'(rd_idx) < LINE_DEPTH);

   // Hold a staged command until the queue has room
   assign push       = stage_valid_ff && !q_stat.full;
   assign req_tready = !stage_valid_ff || !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // Classify the byte and work out the store edit
   always_comb begin
      pos     = (pos_ff >= POS_W'(LINE_DEPTH)) ? '0 : pos_ff;
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(pos);
      wr_data = CHAR_NUL;
      pos_in  = pos_ff;
      done    = 1'b0;
      kind    = KIND_SINGLE;
      if (is_read) begin
         kind = KIND_READ;
      end else begin
         pos_in = pos;
         if (rx == cfg.end_char) begin
            wr_en  = 1'b1;
            pos_in = '0;
            done   = 1'b1;
         end else if (rx == cfg.backspace_char) begin
            wr_en = 1'b1;
            if (pos != '0) begin
               wr_addr = ADDR_W'(pos - POS_W'(1));
               pos_in  = pos - POS_W'(1);
               kind    = KIND_BACKSPACE;
            end else begin
               wr_addr = '0;
               pos_in  = '0;
               done    = 1'b1;
               kind    = KIND_CRLF;
            end
         end else if (rx == cfg.clear_char) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            pos_in  = '0;
            done    = 1'b1;
            kind    = KIND_CLEAR;
         end else if (rx > cfg.printable_floor) begin
            wr_en   = 1'b1;
            wr_data = rx;
            pos_in  = pos + POS_W'(1);
         end
         if (!cfg.echo_enable) kind = KIND_QUIET;
      end
   end

   // Track whether entry 0 holds a character
   assign entry0_in = (wr_en && wr_addr == '0) ? (wr_data != CHAR_NUL) : entry0_ff;

   always_comb begin
      stage_in           = '0;
      stage_in.kind      = kind;
      stage_in.rx_byte   = rx;
      stage_in.line_done = done;
      stage_in.has_data  = entry0_in;
   end

   assign rvld_in        = is_read && in_range && valid_ff[rd_addr];
   assign stage_valid_in = accept ? 1'b1 : (push ? 1'b0 : stage_valid_ff);

   // Attach the read data on the way into the queue
   always_comb begin
      push_cmd           = stage_ff;
      push_cmd.read_data = (stage_ff.kind == KIND_READ && rvld_ff) ? rdata_ff : CHAR_NUL;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         pos_ff         <= '0;
         entry0_ff      <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (accept) begin
            pos_ff    <= pos_in;
            entry0_ff <= entry0_in;
            if (wr_en) valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Line store and staged payload
   always_ff @(posedge clock) begin
      if (accept) begin
         if (wr_en) mem[wr_addr] <= wr_data;
         rdata_ff <= mem[rd_addr];
         rvld_ff  <= rvld_in;
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== design/sleb_queue.sv =====
// Short command queue between the front end and the response back end.
module sleb_queue import sleb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type q_stat
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign q_stat.valid = (count_ff != '0);
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0
                                : wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0
                                : rd_ptr_ff + QPTR_W'(1);
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ===== design/sleb_back.sv =====
// Back end: expands each queued command into its response transactions.
module sleb_back import sleb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  cmd_type          head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic [2:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] data_ff, data_in;
   logic        last_ff;
   logic        load, is_last, echo_on;
   logic [7:0]  echo_byte, read_data;

   assign load    = q_stat.valid && (!rsp_valid_ff || rsp_tready);
   assign is_last = (step_ff == last_step(head_cmd.kind));
   assign pop     = load && is_last;
   assign echo_on = (head_cmd.kind != KIND_READ) && (head_cmd.kind != KIND_QUIET);

   // Build one response
   always_comb begin
      echo_byte = echo_on ? echo_char(head_cmd.kind, step_ff, head_cmd.rx_byte) : CHAR_NUL;
      read_data = (head_cmd.kind == KIND_READ) ? head_cmd.read_data : CHAR_NUL;
      data_in   = {5'b0, read_data, is_last && head_cmd.has_data,
                   is_last && head_cmd.line_done, echo_byte, echo_on};
      step_in   = load ? (is_last ? 3'd0 : step_ff + 3'd1) : step_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= is_last;
      end
   end

endmodule

// ===== design/serial_line_edit_buffer_core.sv =====
// Top level of the serial line edit buffer: configuration registers and block wiring.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tdata: rx_byte, read_index; tuser: operation
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: echo fields, read_data; tlast: last
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// The front end edits the line store and stages the command, which passes from the staging
// register through the queue into the response register.
// Each command then issues one response a cycle unless rsp_tready stalls it: 1, 3 or 8 for
// receives, 1 for reads, so the sustained rate is set by the back end's response sequencer.
// Synchronous reset loads cfg defaults and clears control registers, store valid bits and queue.
// A stalled response side fills the four-entry queue before requests are held off.
module serial_line_edit_buffer_core import sleb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [7:0] rx_byte, [13:8] read_index
   input  logic                 req_tuser,   // [0] operation
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [0] echo_valid, [8:1] echo_byte, [9] line_done,
                                             // [10] has_data, [18:11] read_data
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   cfg_type          cfg_ff;
   queue_status_type q_stat;
   logic             push, pop;
   cmd_type          push_cmd, head_cmd;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.end_char        <= 8'd13;
         cfg_ff.backspace_char  <= 8'd8;
         cfg_ff.clear_char      <= 8'd24;
         cfg_ff.echo_enable     <= 1'b0;
         cfg_ff.printable_floor <= 8'd31;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_END_CHAR:        cfg_ff.end_char        <= csr_data;
            REG_BACKSPACE_CHAR:  cfg_ff.backspace_char  <= csr_data;
            REG_CLEAR_CHAR:      cfg_ff.clear_char      <= csr_data;
            REG_ECHO_ENABLE:     cfg_ff.echo_enable     <= csr_data[0];
            REG_PRINTABLE_FLOOR: cfg_ff.printable_floor <= csr_data;
            default: ;
         endcase
      end
   end

   sleb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   sleb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   sleb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A response without echo always closes its transaction
   a_quiet_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tlast)
      else $error("response without echo is not last");

   // Echo responses never carry read data
   a_echo_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[18:11] == 8'd0)
      else $error("echo response carries read data");

   // Line done and has data appear only on the final response
   a_flags_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9] || rsp_tdata[10]) |-> rsp_tlast)
      else $error("status flag on a non-final response");

   // The queue is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("command queue overflow");

endmodule
